// ----- sv/u8sd_pkg.sv -----
// Package for the UTF-8 stream decoder: beat types, status struct and
// the byte prefix codes. No dependencies.
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CP_W = 21;

  // Prefix tags of the lead and continuation bytes.
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // Continuation bytes still expected after each lead form.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_mark;
  } in_beat_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            malformed;
  } out_beat_t;

  // Status from the sequence tracker to the top level.
  typedef struct packed {
    logic emit;   // this step produces a result beat
    logic busy;   // a multi-byte sequence is open
  } seq_stat_t;

endpackage

`default_nettype wire

// ----- sv/u8sd_seq.sv -----
// Sequence tracker of the UTF-8 stream decoder: pending count, payload
// accumulator and bad flag, plus the per-byte decode. Uses u8sd_pkg.
`default_nettype none

module u8sd_seq (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,
  input  u8sd_pkg::in_beat_t    beat,
  output u8sd_pkg::seq_stat_t   stat,
  output u8sd_pkg::out_beat_t   result
);
  import u8sd_pkg::*;

  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] acc_r, acc_nxt;
  logic            bad_r, bad_nxt;

  logic [1:0]      pend_dec;
  logic [CP_W-1:0] acc_shift;
  logic            bad_cont;
  logic [7:0]      b;

  assign b         = beat.in_byte;
  assign pend_dec  = pend_r - 2'd1;
  assign acc_shift = {acc_r[CP_W-7:0], b[5:0]};
  assign bad_cont  = bad_r | (b[7:6] != CONT_TAG);

  always_comb begin
    pend_nxt          = pend_r;
    acc_nxt           = acc_r;
    bad_nxt           = bad_r;
    stat.emit         = 1'b0;
    stat.busy         = (pend_r != PEND_NONE);
    result.code_point = '0;
    result.malformed  = 1'b0;
    if (step) begin
      if (beat.end_mark) begin
        // A cut-short sequence reports malformed; an idle end mark is silent.
        pend_nxt         = PEND_NONE;
        acc_nxt          = '0;
        bad_nxt          = 1'b0;
        stat.emit        = (pend_r != PEND_NONE);
        result.malformed = 1'b1;
      end else if (pend_r != PEND_NONE) begin
        if (pend_dec == PEND_NONE) begin
          stat.emit         = 1'b1;
          result.code_point = bad_cont ? '0 : acc_shift;
          result.malformed  = bad_cont;
          pend_nxt          = PEND_NONE;
          acc_nxt           = '0;
          bad_nxt           = 1'b0;
        end else begin
          pend_nxt = pend_dec;
          acc_nxt  = acc_shift;
          bad_nxt  = bad_cont;
        end
      end else if (!b[7]) begin
        stat.emit         = 1'b1;
        result.code_point = {{(CP_W-8){1'b0}}, b};
      end else if (b[7:5] == LEAD2_TAG) begin
        pend_nxt = PEND_ONE;
        acc_nxt  = {{(CP_W-5){1'b0}}, b[4:0]};
        bad_nxt  = 1'b0;
      end else if (b[7:4] == LEAD3_TAG) begin
        pend_nxt = PEND_TWO;
        acc_nxt  = {{(CP_W-4){1'b0}}, b[3:0]};
        bad_nxt  = 1'b0;
      end else if (b[7:3] == LEAD4_TAG) begin
        pend_nxt = PEND_THREE;
        acc_nxt  = {{(CP_W-3){1'b0}}, b[2:0]};
        bad_nxt  = 1'b0;
      end else begin
        stat.emit        = 1'b1;
        result.malformed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      acc_r  <= '0;
      bad_r  <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/u8sd_out_reg.sv -----
// Result register of the UTF-8 stream decoder, holding one beat for the
// out channel. Uses u8sd_pkg.
`default_nettype none

module u8sd_out_reg (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   load,
  input  u8sd_pkg::out_beat_t   load_data,
  output logic                  can_take,
  output logic                  out_valid,
  input  wire                   out_ready,
  output u8sd_pkg::out_beat_t   out_data
);
  import u8sd_pkg::*;

  logic      vld_r, vld_nxt;
  out_beat_t data_r;

  // Room for a new beat if empty or the held beat leaves this cycle.
  assign can_take  = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_data  = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// Top level of the UTF-8 stream decoder: input register, sequence tracker
// and result register. Uses u8sd_pkg, u8sd_seq and u8sd_out_reg.
//
//   Channel | Direction | Handshake            | Beat
//   in_     | input     | in_valid / in_ready  | in_beat_t  (in_byte, end_mark)
//   out_    | output    | out_valid / out_ready| out_beat_t (code_point, malformed)
//
// Each byte waits in the input register while the combinational decode step
// runs; the step's result is then registered in the result register and is
// shown on out_ from there.
// Sustained rate is one byte per clock unless out_ stalls; single decode step.
// Reset is synchronous on rst_n low and clears the sequence state and valids.
// A stalled result holds in the output register; the input register keeps
// taking beats as long as the output register has or frees room.
`default_nettype none

module utf8_stream_decoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  u8sd_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output u8sd_pkg::out_beat_t  out_data
);
  import u8sd_pkg::*;

  // Input register: one byte beat waiting for the decode step.
  logic      in_vld_r, in_vld_nxt;
  in_beat_t  in_data_r;

  seq_stat_t seq_stat;
  out_beat_t seq_result;
  logic      can_take;
  logic      step;

  // The decode step runs whenever a beat is held and the result register
  // can take whatever the step produces.
  assign step     = in_vld_r && can_take;
  assign in_ready = !in_vld_r || step;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  u8sd_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .beat   (in_data_r),
    .stat   (seq_stat),
    .result (seq_result)
  );

  u8sd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (seq_stat.emit),
    .load_data (seq_result),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A malformed result always carries a zero code point.
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.malformed && (out_data.code_point != '0)))
    else $error("malformed result with nonzero code point");

  // An end mark inside an open sequence yields a malformed result.
  a_trunc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data_r.end_mark && seq_stat.busy) |=> (out_valid && out_data.malformed))
    else $error("truncated sequence not flagged");

  // A plain ASCII byte outside a sequence comes out as itself.
  a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !in_data_r.end_mark && !seq_stat.busy && !in_data_r.in_byte[7])
    |=> (out_valid && !out_data.malformed &&
         (out_data.code_point == {{(CP_W-8){1'b0}}, $past(in_data_r.in_byte)})))
    else $error("ASCII byte decoded wrongly");

  // A held byte that cannot step stays put.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !can_take) |=> (in_vld_r && $stable(in_data_r)))
    else $error("input register lost a held byte");

endmodule

`default_nettype wire
